// ===== sv/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and codes for the indexed sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_PUSH   = 3'd2,
        OP_POP    = 3'd3,
        OP_INSERT = 3'd4,
        OP_ERASE  = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PLACE,
        S_FETCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [6:0]         position;
        logic signed [31:0] value;
        logic [6:0]         erase_count;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         element_count;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               is_empty;
    } res_t;

    // Controller to datapath.
    typedef struct packed {
        logic latch;
        logic decode;
        logic move_rd;
        logic move_wr;
        logic place;
        logic fetch;
        logic done;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic ok;
        logic shift_op;
        logic more;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered store of signed words with positional read, write, insert and erase, plus push, pop and clear.
// ----------------------------------------------------------------------------
// A request beat is taken on a rising edge where start is high and busy is
// low; request carries the operation, position, value and erase count.
// Exactly one result beat follows per request: done is high for one cycle
// and result holds status, the read element, the count, the front and back
// elements and the empty flag. The receiver cannot stall, so the result must
// be captured in that cycle.
// Every operation except a successful insert or erase goes from accept
// through decode, fetch and result. Those two move elements through the
// single-write element memory, each by a read then a write, between decode
// and the last move check, then do the final write or count update, fetch
// and result; an insert at position p moves count - p elements and an
// erase moves the elements above the run.
// busy stays high from accept until done, and a new request is taken the
// cycle after done, so a new request is never taken while one is in flight.
// Reset empties the store at once; the element memory itself is not
// cleared, and no entry below the count is ever unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_sequence_store
    import iss_pkg::*;
#(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t request,
    output logic      busy,
    output logic      done,
    output res_t      result
);

    cmd_t  cmd;
    stat_t stat;

    // The sequencer steps through decode, element moves and the final
    // front/back fetch; the datapath holds the memory and the count.
    iss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    iss_datapath #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    assign done = cmd.done;

`ifndef ASSERT_OFF
    // A result beat only ends a busy request.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");

    // After a result the block is free again.
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after done");

    // An accepted beat makes the block busy next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done)) else $error("accept lost");

    // Empty flag agrees with the count when DEPTH is at most 127.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.element_count == '0) || DEPTH > 127))
        else $error("empty flag mismatch");
`endif

endmodule

`default_nettype wire

// ===== sv/iss_ctrl.sv =====
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer for the indexed sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_ctrl
    import iss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output logic       busy,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = (stat.ok && stat.shift_op) ? S_MOVE_RD : S_FETCH;
            end
            S_MOVE_RD:
            begin
                state_next = stat.more ? S_MOVE_WR : S_PLACE;
            end
            S_MOVE_WR: state_next = S_MOVE_RD;
            S_PLACE:   state_next = S_FETCH;
            S_FETCH:   state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        cmd         = '0;
        cmd.latch   = (state_reg == S_IDLE) && start;
        cmd.decode  = (state_reg == S_DECODE);
        cmd.move_rd = (state_reg == S_MOVE_RD) && stat.more;
        cmd.move_wr = (state_reg == S_MOVE_WR);
        cmd.place   = (state_reg == S_PLACE);
        cmd.fetch   = (state_reg == S_FETCH);
        cmd.done    = (state_reg == S_DONE);
    end

endmodule

`default_nettype wire

// ===== sv/iss_datapath.sv =====
// ----------------------------------------------------------------------------
// iss_datapath
// Element memory, count, move index and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_datapath
    import iss_pkg::*;
#(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t request,
    input  wire cmd_t cmd,
    output stat_t     stat,
    output res_t      result
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;
    localparam int XW     = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;

    logic [ELEMENT_WIDTH-1:0] mem [DEPTH];
    logic [ELEMENT_WIDTH-1:0] q_a_reg;
    logic [ELEMENT_WIDTH-1:0] q_b_reg;

    req_t               req_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    status_t            status_reg;
    status_t            status_now;
    logic signed [31:0] rd_reg;

    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] count_x;
    logic [CMP_W-1:0] idx_x;
    op_t              op;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;
    logic [ELEMENT_WIDTH-1:0] val_e;
    logic [ADDR_W-1:0]        src_addr;

    function automatic logic signed [31:0] out_form(input logic [ELEMENT_WIDTH-1:0] e);
        logic signed [XW-1:0] x;
        x = XW'($signed(e));
        return x[31:0];
    endfunction

    assign op      = op_t'(req_reg.operation);
    assign pos_x   = CMP_W'(req_reg.position);
    assign cnt_x   = CMP_W'(req_reg.erase_count);
    assign count_x = CMP_W'(count_reg);
    assign idx_x   = CMP_W'(idx_reg);
    assign val_e   = ELEMENT_WIDTH'($signed(req_reg.value));

    always_comb
    begin
        status_now = ST_OK;
        unique case (op)
            OP_READ, OP_WRITE:
            begin
                if (pos_x >= count_x) status_now = ST_RANGE;
            end
            OP_PUSH:
            begin
                if (count_x >= CMP_W'(DEPTH)) status_now = ST_FULL;
            end
            OP_POP:
            begin
                if (count_x == '0) status_now = ST_EMPTY;
            end
            OP_INSERT:
            begin
                if (pos_x > count_x) status_now = ST_RANGE;
                else if (count_x >= CMP_W'(DEPTH)) status_now = ST_FULL;
            end
            OP_ERASE:
            begin
                if (pos_x >= count_x || pos_x + cnt_x > count_x) status_now = ST_RANGE;
            end
            default: status_now = ST_OK;
        endcase
    end

    assign stat.ok       = (status_now == ST_OK);
    assign stat.shift_op = (op == OP_INSERT) || (op == OP_ERASE);
    assign stat.more     = (op == OP_INSERT) ? (idx_x > pos_x) : (idx_x + cnt_x < count_x);

    assign src_addr = (op == OP_INSERT) ? ADDR_W'(idx_reg - 1'b1)
                                        : ADDR_W'(idx_x + cnt_x);

    // Write port and read port A and B address selection.
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = ADDR_W'(req_reg.position);
        wr_data   = val_e;
        rd_addr_a = '0;
        rd_addr_b = ADDR_W'(count_reg - 1'b1);
        if (cmd.decode)
        begin
            rd_addr_a = ADDR_W'(req_reg.position);
            if (status_now == ST_OK && op == OP_WRITE)
            begin
                wr_en = 1'b1;
            end
            if (status_now == ST_OK && op == OP_PUSH)
            begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(count_reg);
            end
        end
        if (cmd.move_rd)
        begin
            rd_addr_a = src_addr;
        end
        if (cmd.move_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(idx_reg);
            wr_data = q_a_reg;
        end
        if (cmd.place && op == OP_INSERT)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_a_reg <= mem[rd_addr_a];
        q_b_reg <= mem[rd_addr_b];
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.decode && status_now == ST_OK)
        begin
            unique case (op)
                OP_PUSH:   count_next = count_reg + 1'b1;
                OP_POP:    count_next = count_reg - 1'b1;
                OP_CLEAR:  count_next = '0;
                OP_INSERT: idx_next   = count_reg;
                OP_ERASE:  idx_next   = CNT_W'(req_reg.position);
                default:   count_next = count_reg;
            endcase
        end
        if (cmd.move_wr)
        begin
            idx_next = (op == OP_INSERT) ? idx_reg - 1'b1 : idx_reg + 1'b1;
        end
        if (cmd.place)
        begin
            count_next = (op == OP_INSERT) ? count_reg + 1'b1
                                           : CNT_W'(count_x - cnt_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.latch)
        begin
            req_reg <= request;
        end
        if (cmd.decode)
        begin
            status_reg <= status_now;
        end
        if (cmd.fetch)
        begin
            rd_reg <= (op == OP_READ && status_reg == ST_OK) ? out_form(q_a_reg) : '0;
        end
    end

    always_comb
    begin
        result.status        = status_reg;
        result.read_value    = rd_reg;
        result.element_count = 7'(count_reg);
        result.is_empty      = (count_reg == '0);
        result.front_value   = result.is_empty ? '0 : out_form(q_a_reg);
        result.back_value    = result.is_empty ? '0 : out_form(q_b_reg);
    end

endmodule

`default_nettype wire
